FILE: src/max_pool_2x2_stride2_assert.svh
// ----------------------------------------------------------------------------
// Max pool 2x2 stride 2: assertion macros
// Short forms for clocked assertions on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef MAX_POOL_2X2_STRIDE2_ASSERT_SVH
`define MAX_POOL_2X2_STRIDE2_ASSERT_SVH

// Consequent checked at the same edge as the antecedent.
`define MP22_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("max pool assertion failed");

// Consequent checked at the edge after the antecedent.
`define MP22_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("max pool assertion failed");

`endif

FILE: src/mp22_pkg.sv
// ----------------------------------------------------------------------------
// Max pool 2x2 stride 2: package
// Shared constants, register codes and types of the pooling block.
// ----------------------------------------------------------------------------
`default_nettype none

package mp22_pkg;

	// Defaults of the top-level parameters
	localparam int MAX_WIDTH_DEF   = 1024;
	localparam int SAMPLE_BITS_DEF = 16;

	// Register and counter widths
	localparam int REG_W        = 11;
	localparam int ROW_W        = 10;
	localparam int CHAN_W       = 10;
	localparam int MAX_HEIGHT   = 1024;
	localparam int MAX_CHANNELS = 1024;

	// APB port
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;
	localparam int IDX_W   = PADDR_W - 2;

	// Register indexes (byte address divided by four)
	localparam logic [IDX_W-1:0] REG_FRAME_WIDTH   = IDX_W'(0);
	localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT  = IDX_W'(1);
	localparam logic [IDX_W-1:0] REG_CHANNEL_COUNT = IDX_W'(2);

	// Reset values of the registers
	localparam logic [REG_W-1:0] FRAME_WIDTH_RST   = REG_W'(32);
	localparam logic [REG_W-1:0] FRAME_HEIGHT_RST  = REG_W'(32);
	localparam logic [REG_W-1:0] CHANNEL_COUNT_RST = REG_W'(1);

	// Tensor geometry as held by the register file
	typedef struct packed {
		logic [REG_W-1:0] frame_width;
		logic [REG_W-1:0] frame_height;
		logic [REG_W-1:0] channel_count;
	} cfg_t;

	// Position of the current sample within its window and tensor
	typedef struct packed {
		logic active;
		logic odd_col;
		logic odd_row;
		logic last;
	} pos_t;

endpackage

`default_nettype wire

FILE: src/mp22_stream_if.sv
// ----------------------------------------------------------------------------
// Max pool 2x2 stride 2: stream interfaces
// Valid/ready channels for input samples and pooled results.
// ----------------------------------------------------------------------------
`default_nettype none

interface mp22_sample_if #(
	parameter int SAMPLE_BITS = mp22_pkg::SAMPLE_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink   (input valid, input sample, output ready);
endinterface

interface mp22_result_if #(
	parameter int SAMPLE_BITS = mp22_pkg::SAMPLE_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] pooled;
	logic                          tensor_end;

	modport source (output valid, output pooled, output tensor_end, input ready);
	modport sink   (input valid, input pooled, input tensor_end, output ready);
endinterface

`default_nettype wire

FILE: src/mp22_ram.sv
// ----------------------------------------------------------------------------
// Max pool 2x2 stride 2: generic RAM
// One write port, one read port, read data registered and held without rd_en.
// ----------------------------------------------------------------------------
`default_nettype none

module mp22_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 512
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output      logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write the entry, register the read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

FILE: src/mp22_cfg.sv
// ----------------------------------------------------------------------------
// Max pool 2x2 stride 2: register file
// APB-style registers for width, height and channel count, clamped on write.
// ----------------------------------------------------------------------------
`default_nettype none

module mp22_cfg #(
	parameter int MAX_WIDTH = mp22_pkg::MAX_WIDTH_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [mp22_pkg::PADDR_W-1:0] paddr,
	input  wire logic [mp22_pkg::PDATA_W-1:0] pwdata,
	output      logic [mp22_pkg::PDATA_W-1:0] prdata,
	output      logic                         pready,
	output      mp22_pkg::cfg_t               cfg
);

	localparam int REG_W = mp22_pkg::REG_W;

	mp22_pkg::cfg_t                 cfg_q;
	logic                           wr_en;
	logic [mp22_pkg::IDX_W-1:0]     idx;
	logic [REG_W-1:0]               wr_val;
	logic [REG_W-1:0]               rd_val;

	// Limit a value to [lo, hi]
	function automatic logic [REG_W-1:0] clamp(input logic [REG_W-1:0] v,
			input int lo, input int hi);
		logic [REG_W-1:0] r;
		if (32'(v) < lo) begin
			r = REG_W'(lo);
		end else if (32'(v) > hi) begin
			r = REG_W'(hi);
		end else begin
			r = v;
		end
		return r;
	endfunction

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = paddr[mp22_pkg::PADDR_W-1:2];
	assign wr_val = pwdata[REG_W-1:0];
	assign cfg    = cfg_q;

	// Take a register write at the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_width   <= mp22_pkg::FRAME_WIDTH_RST;
			cfg_q.frame_height  <= mp22_pkg::FRAME_HEIGHT_RST;
			cfg_q.channel_count <= mp22_pkg::CHANNEL_COUNT_RST;
		end else if (wr_en) begin
			unique case (idx)
				mp22_pkg::REG_FRAME_WIDTH: begin
					cfg_q.frame_width <= clamp(wr_val, 2, MAX_WIDTH);
				end
				mp22_pkg::REG_FRAME_HEIGHT: begin
					cfg_q.frame_height <= clamp(wr_val, 2, mp22_pkg::MAX_HEIGHT);
				end
				mp22_pkg::REG_CHANNEL_COUNT: begin
					cfg_q.channel_count <= clamp(wr_val, 1, mp22_pkg::MAX_CHANNELS);
				end
				default: begin
				end
			endcase
		end
	end

	// Return the addressed register, zero beyond the map
	always_comb begin
		unique case (idx)
			mp22_pkg::REG_FRAME_WIDTH:   rd_val = cfg_q.frame_width;
			mp22_pkg::REG_FRAME_HEIGHT:  rd_val = cfg_q.frame_height;
			mp22_pkg::REG_CHANNEL_COUNT: rd_val = cfg_q.channel_count;
			default:                     rd_val = '0;
		endcase
	end

	assign prdata = mp22_pkg::PDATA_W'(rd_val);

endmodule

`default_nettype wire

FILE: src/mp22_walk.sv
// ----------------------------------------------------------------------------
// Max pool 2x2 stride 2: raster walker
// Column, row and channel counters; flags the window role of each sample.
// ----------------------------------------------------------------------------
`default_nettype none

module mp22_walk #(
	parameter int MAX_WIDTH = mp22_pkg::MAX_WIDTH_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire mp22_pkg::cfg_t                      cfg,
	input  wire logic                                step,
	output      mp22_pkg::pos_t                      pos,
	output      logic [$clog2(MAX_WIDTH / 2)-1:0]    slot
);

	localparam int REG_W  = mp22_pkg::REG_W;
	localparam int ROW_W  = mp22_pkg::ROW_W;
	localparam int CHAN_W = mp22_pkg::CHAN_W;
	localparam int CW     = $clog2(MAX_WIDTH);
	localparam int SLOT_W = $clog2(MAX_WIDTH / 2);
	localparam int CMP_W  = ((CW > REG_W) ? CW : REG_W) + 1;
	localparam int RW1    = REG_W + 1;

	logic [CW-1:0]     col_q;
	logic [ROW_W-1:0]  row_q;
	logic [CHAN_W-1:0] chan_q;
	logic [CMP_W-1:0]  col_inc;
	logic [CMP_W-1:0]  used_w;
	logic [RW1-1:0]    row_inc;
	logic [RW1-1:0]    chan_inc;
	logic [RW1-1:0]    used_h;

	// Next counts and the even part of the geometry
	assign col_inc  = CMP_W'(col_q) + CMP_W'(1);
	assign row_inc  = RW1'(row_q) + RW1'(1);
	assign chan_inc = RW1'(chan_q) + RW1'(1);
	assign used_w   = CMP_W'({cfg.frame_width[REG_W-1:1], 1'b0});
	assign used_h   = RW1'({cfg.frame_height[REG_W-1:1], 1'b0});

	// Role of the current sample in its window
	assign pos.active  = (CMP_W'(col_q) < used_w) && (RW1'(row_q) < used_h);
	assign pos.odd_col = col_q[0];
	assign pos.odd_row = row_q[0];
	assign pos.last    = (chan_inc >= RW1'(cfg.channel_count)) &&
	                     (row_inc == used_h) && (col_inc == used_w);
	assign slot        = col_q[SLOT_W:1];

	// Advance the raster position on each transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			chan_q <= '0;
		end else if (step) begin
			if (col_inc >= CMP_W'(cfg.frame_width)) begin
				col_q <= '0;
				if (row_inc >= RW1'(cfg.frame_height)) begin
					row_q <= '0;
					if (chan_inc >= RW1'(cfg.channel_count)) begin
						chan_q <= '0;
					end else begin
						chan_q <= chan_inc[CHAN_W-1:0];
					end
				end else begin
					row_q <= row_inc[ROW_W-1:0];
				end
			end else begin
				col_q <= col_inc[CW-1:0];
			end
		end
	end

endmodule

`default_nettype wire

FILE: src/max_pool_2x2_stride2.sv
// ----------------------------------------------------------------------------
// Max pool 2x2 stride 2: top level
// Streaming 2x2 max pooling over a channel-major tensor with a line buffer.
// ----------------------------------------------------------------------------
// The block takes one sample per clock cycle without pause as long as the
// result side keeps up; each odd-row, odd-column sample yields one pooled
// value through the registered line-buffer read (stage one) and then the
// output register. Pair maxima of each even row live in a MAX_WIDTH/2-entry
// RAM, written on the even row and read back at the same column pair of the
// following odd row, so a read never meets a write to its entry in flight.
// The line buffer needs no clearing after reset. The last column or row of
// an odd-sized frame is consumed and ignored, and tensor_end marks the final
// pooled value of the tensor.
`default_nettype none

module max_pool_2x2_stride2 #(
	parameter int MAX_WIDTH   = mp22_pkg::MAX_WIDTH_DEF,
	parameter int SAMPLE_BITS = mp22_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [mp22_pkg::PADDR_W-1:0] paddr,
	input  wire logic [mp22_pkg::PDATA_W-1:0] pwdata,
	output      logic [mp22_pkg::PDATA_W-1:0] prdata,
	output      logic                         pready,
	mp22_sample_if.sink                       samples,
	mp22_result_if.source                     results
);

	localparam int DEPTH  = MAX_WIDTH / 2;
	localparam int SLOT_W = $clog2(DEPTH);

	mp22_pkg::cfg_t                cfg;
	mp22_pkg::pos_t                pos;
	logic [SLOT_W-1:0]             slot;
	logic                          accept;
	logic                          advance;
	logic                          hold_en;
	logic                          wr_en;
	logic                          rd_en;
	logic signed [SAMPLE_BITS-1:0] held_q;
	logic signed [SAMPLE_BITS-1:0] pair_max;
	logic signed [SAMPLE_BITS-1:0] line_max;
	logic [SAMPLE_BITS-1:0]        rd_data;
	logic                          valid_s1;
	logic signed [SAMPLE_BITS-1:0] pair_s1;
	logic                          last_s1;
	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] pooled_q;
	logic                          end_q;

	mp22_cfg #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	mp22_walk #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_walk (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.step   (accept),
		.pos    (pos),
		.slot   (slot)
	);

	// Output register frees when empty or taken; stage one moves into it then
	assign advance       = !out_valid_q || results.ready;
	assign samples.ready = !valid_s1 || advance;
	assign accept        = samples.valid && samples.ready;

	// Sample roles: hold on even column, store pair on even row, read on odd row
	assign hold_en  = accept && pos.active && !pos.odd_col;
	assign wr_en    = accept && pos.active && pos.odd_col && !pos.odd_row;
	assign rd_en    = accept && pos.active && pos.odd_col && pos.odd_row;
	assign pair_max = (samples.sample > held_q) ? samples.sample : held_q;

	mp22_ram #(
		.WIDTH (SAMPLE_BITS),
		.DEPTH (DEPTH)
	) u_line (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (slot),
		.wr_data (pair_max),
		.rd_en   (rd_en),
		.rd_addr (slot),
		.rd_data (rd_data)
	);

	// Hold the even-column sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
		end else if (hold_en) begin
			held_q <= samples.sample;
		end
	end

	// Stage one: window waits for the line-buffer read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= rd_en;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			pair_s1 <= pair_max;
			last_s1 <= pos.last;
		end
	end

	// Combine the stored pair with the current pair
	assign line_max = (pair_s1 > $signed(rd_data)) ? pair_s1 : $signed(rd_data);

	// Output register: load from stage one, drop on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (valid_s1 && advance) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			pooled_q <= line_max;
			end_q    <= last_s1;
		end
	end

	assign results.valid      = out_valid_q;
	assign results.pooled     = pooled_q;
	assign results.tensor_end = end_q;

endmodule

`default_nettype wire

FILE: src/mp22_checker.sv
// ----------------------------------------------------------------------------
// Max pool 2x2 stride 2: port checker
// Timing checks on the stream ports, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "max_pool_2x2_stride2_assert.svh"

module mp22_checker #(
	parameter int SAMPLE_BITS = mp22_pkg::SAMPLE_BITS_DEF
) (
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   in_valid,
	input wire logic                   in_ready,
	input wire logic                   res_valid,
	input wire logic                   res_ready,
	input wire logic [SAMPLE_BITS-1:0] res_pooled,
	input wire logic                   res_end
);

	// A stalled result keeps its value
	`MP22_ASSERT_NEXT(a_result_holds, res_valid && !res_ready,
		res_valid && $stable(res_pooled) && $stable(res_end))

	// A new result must follow an earlier sample transfer
	`MP22_ASSERT_SAME(a_result_after_transfer, $rose(res_valid),
		$past(in_valid && in_ready, 2))

	// With the output register empty the input side must be open
	`MP22_ASSERT_SAME(a_ready_when_empty, !res_valid, in_ready)

endmodule

bind max_pool_2x2_stride2 mp22_checker #(
	.SAMPLE_BITS (SAMPLE_BITS)
) u_mp22_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (samples.valid),
	.in_ready   (samples.ready),
	.res_valid  (results.valid),
	.res_ready  (results.ready),
	.res_pooled (results.pooled),
	.res_end    (results.tensor_end)
);

`default_nettype wire
